>>> hw/rtl/twsw_pkg.sv
// Shared types and constants of the two-wire serial write master.
`default_nettype none
package twsw_pkg;

	// Command codes on the input mode field.
	localparam logic [1:0] MODE_START = 2'd0;
	localparam logic [1:0] MODE_STOP  = 2'd1;
	localparam logic [1:0] MODE_WRITE = 2'd2;

	// Configuration register indexes.
	localparam logic CFG_PHASE_HOLD  = 1'b0;
	localparam logic CFG_ACK_TIMEOUT = 1'b1;

	localparam int CFG_DATA_W = 16;
	localparam int HOLD_W     = 16;
	localparam int TIMEOUT_W  = 10;

	localparam logic [HOLD_W-1:0]    PHASE_HOLD_RESET  = 16'd100;
	localparam logic [TIMEOUT_W-1:0] ACK_TIMEOUT_RESET = 10'd300;

	// Phase positions inside a byte write.
	localparam logic [4:0] WR_BITS_END  = 5'd24;
	localparam logic [4:0] WR_ACK_CLK_L = 5'd24;
	localparam logic [4:0] WR_ACK_DIO_H = 5'd25;
	localparam logic [4:0] WR_ACK_CLK_H = 5'd26;
	localparam logic [4:0] WR_RELEASE   = 5'd27;
	localparam logic [4:0] WR_REDRIVE   = 5'd28;
	localparam logic [4:0] WR_DIO_LOW   = 5'd29;

	typedef enum logic [1:0] {
		KIND_START,
		KIND_STOP,
		KIND_WRITE
	} cmd_kind_t;

	typedef enum logic {
		SEQ_IDLE,
		SEQ_RUN
	} seq_state_t;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] data_byte;
		logic       dio_in;
	} cmd_t;

	typedef struct packed {
		logic clk_level;
		logic dio_level;
		logic dio_drive;
		logic ack_seen;
		logic last_phase;
	} rsp_t;

	// A classified command as it waits between the front and the sequencer.
	typedef struct packed {
		cmd_kind_t  kind;
		logic [7:0] data_byte;
		logic       ack;
	} cmd_entry_t;

endpackage
`default_nettype wire

>>> hw/rtl/twsw_cmd_front.sv
// Command front end: accepts requests, classifies them and queues them for the sequencer.
`default_nettype none
module twsw_cmd_front (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	output logic                full,
	input  wire twsw_pkg::cmd_t cmd,
	output logic                entry_valid,
	output twsw_pkg::cmd_entry_t entry,
	input  wire                 entry_take
);

	twsw_pkg::cmd_entry_t slot_q [2];
	logic [1:0]           count_q;
	logic                 wr_ptr_q;
	logic                 rd_ptr_q;
	logic                 accept;
	logic                 known;
	logic                 enq;
	logic                 deq;
	twsw_pkg::cmd_entry_t classified;

	assign full        = (count_q == 2'd2);
	assign accept      = push && !full;
	assign entry_valid = (count_q != 2'd0);
	assign entry       = slot_q[rd_ptr_q];
	assign deq         = entry_take && entry_valid;
	assign enq         = accept && known;

	// An unused mode is taken and dropped here, so it never reaches the back end.
	always_comb begin
		known                = 1'b1;
		classified.kind      = twsw_pkg::KIND_START;
		classified.data_byte = cmd.data_byte;
		classified.ack       = !cmd.dio_in;
		case (cmd.mode)
			twsw_pkg::MODE_START: classified.kind = twsw_pkg::KIND_START;
			twsw_pkg::MODE_STOP:  classified.kind = twsw_pkg::KIND_STOP;
			twsw_pkg::MODE_WRITE: classified.kind = twsw_pkg::KIND_WRITE;
			default:              known = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (enq) begin
			slot_q[wr_ptr_q] <= classified;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= 2'd0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (enq) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (deq) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({enq, deq})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

>>> hw/rtl/twsw_phase_seq.sv
// Phase sequencer: walks the pin phases of one command and holds each for the set time.
`default_nettype none
module twsw_phase_seq (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire [twsw_pkg::HOLD_W-1:0]    phase_hold,
	input  wire [twsw_pkg::TIMEOUT_W-1:0] ack_timeout,
	input  wire                          entry_valid,
	input  wire twsw_pkg::cmd_entry_t    entry,
	output logic                         entry_take,
	output logic                         rsp_push,
	output twsw_pkg::rsp_t               rsp,
	input  wire                          rsp_full
);

	twsw_pkg::seq_state_t           state_q;
	twsw_pkg::seq_state_t           state_d;
	twsw_pkg::cmd_kind_t            kind_q;
	logic [7:0]                     byte_q;
	logic                           ack_q;
	logic [4:0]                     phase_q;
	logic [1:0]                     sub_q;
	logic [twsw_pkg::HOLD_W-1:0]    hold_q;
	logic [twsw_pkg::TIMEOUT_W-1:0] poll_q;
	logic                           clk_pin_q;
	logic                           dio_pin_q;
	logic                           dir_q;
	logic                           emit;
	logic                           n_clk;
	logic                           n_dio;
	logic                           n_dir;
	logic                           last;
	logic                           in_bits;

	assign in_bits = (kind_q == twsw_pkg::KIND_WRITE) && (phase_q < twsw_pkg::WR_BITS_END);
	assign emit    = (state_q == twsw_pkg::SEQ_RUN) && (hold_q == '0) && (poll_q == '0)
		&& !rsp_full;

	// Pin change of the current phase.
	always_comb begin
		n_clk = clk_pin_q;
		n_dio = dio_pin_q;
		n_dir = dir_q;
		last  = 1'b0;
		case (kind_q)
			twsw_pkg::KIND_START: begin
				case (phase_q[1:0])
					2'd0:    n_dio = 1'b0;
					2'd1:    n_clk = 1'b0;
					2'd2:    n_dio = 1'b1;
					default: begin
						n_clk = 1'b1;
						last  = 1'b1;
					end
				endcase
			end
			twsw_pkg::KIND_STOP: begin
				case (phase_q[1:0])
					2'd0:    n_clk = 1'b0;
					2'd1:    n_dio = 1'b0;
					2'd2:    n_clk = 1'b1;
					default: begin
						n_dio = 1'b1;
						last  = 1'b1;
					end
				endcase
			end
			twsw_pkg::KIND_WRITE: begin
				if (in_bits) begin
					case (sub_q)
						2'd0:    n_clk = 1'b0;
						2'd1:    n_dio = byte_q[0];
						default: n_clk = 1'b1;
					endcase
				end else begin
					case (phase_q)
						twsw_pkg::WR_ACK_CLK_L: n_clk = 1'b0;
						twsw_pkg::WR_ACK_DIO_H: n_dio = 1'b1;
						twsw_pkg::WR_ACK_CLK_H: n_clk = 1'b1;
						twsw_pkg::WR_RELEASE:   n_dir = 1'b0;
						twsw_pkg::WR_REDRIVE:   n_dir = 1'b1;
						default: begin
							n_dio = 1'b0;
							last  = 1'b1;
						end
					endcase
				end
			end
			default: last = 1'b1;
		endcase
	end

	always_comb begin
		rsp_push       = emit;
		rsp.clk_level  = n_clk;
		rsp.dio_level  = n_dio;
		rsp.dio_drive  = n_dir;
		rsp.ack_seen   = last && (kind_q == twsw_pkg::KIND_WRITE) && ack_q;
		rsp.last_phase = last;
	end

	always_comb begin
		state_d    = state_q;
		entry_take = 1'b0;
		case (state_q)
			twsw_pkg::SEQ_IDLE: begin
				if (entry_valid) begin
					entry_take = 1'b1;
					state_d    = twsw_pkg::SEQ_RUN;
				end
			end
			twsw_pkg::SEQ_RUN: begin
				if (emit && last) begin
					state_d = twsw_pkg::SEQ_IDLE;
				end
			end
			default: state_d = twsw_pkg::SEQ_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= twsw_pkg::SEQ_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clk_pin_q <= 1'b0;
			dio_pin_q <= 1'b0;
			dir_q     <= 1'b1;
			hold_q    <= '0;
			poll_q    <= '0;
			phase_q   <= 5'd0;
			sub_q     <= 2'd0;
			kind_q    <= twsw_pkg::KIND_START;
		end else begin
			if (hold_q != '0) begin
				hold_q <= hold_q - 1'b1;
			end
			if (poll_q != '0) begin
				poll_q <= poll_q - 1'b1;
			end
			if (entry_take) begin
				kind_q  <= entry.kind;
				phase_q <= 5'd0;
				sub_q   <= 2'd0;
			end else if (emit) begin
				clk_pin_q <= n_clk;
				dio_pin_q <= n_dio;
				dir_q     <= n_dir;
				phase_q   <= phase_q + 5'd1;
				hold_q    <= (phase_hold == '0) ? '0 : phase_hold - 1'b1;
				if (in_bits) begin
					sub_q <= (sub_q == 2'd2) ? 2'd0 : sub_q + 2'd1;
				end
				// Without an acknowledge the release window runs to the poll limit.
				if ((kind_q == twsw_pkg::KIND_WRITE) && (phase_q == twsw_pkg::WR_RELEASE)
					&& !ack_q) begin
					poll_q <= ack_timeout;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (entry_take) begin
			byte_q <= entry.data_byte;
			ack_q  <= entry.ack;
		end else if (emit && in_bits && (sub_q == 2'd2)) begin
			byte_q <= {1'b0, byte_q[7:1]};
		end
	end

endmodule
`default_nettype wire

>>> hw/rtl/twsw_rsp_fifo.sv
// Two-entry result queue between the sequencer and the result port.
`default_nettype none
module twsw_rsp_fifo (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 wr,
	input  wire twsw_pkg::rsp_t wr_data,
	output logic                full,
	output logic                empty,
	input  wire                 pop,
	output twsw_pkg::rsp_t      rd_data
);

	twsw_pkg::rsp_t slot_q [2];
	logic [1:0]     count_q;
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic           enq;
	logic           deq;

	assign full    = (count_q == 2'd2);
	assign empty   = (count_q == 2'd0);
	assign enq     = wr && !full;
	assign deq     = pop && !empty;
	assign rd_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (enq) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= 2'd0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (enq) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (deq) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({enq, deq})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

>>> hw/rtl/two_wire_serial_write_master_unit.sv
// Top level of the two-wire serial write master: config registers, front end, sequencer, queue.
//
// Usage. Commands enter through a queue-style port: a request is taken at a clock edge with
// push high and full low. Mode start sends a start condition, mode stop a stop condition,
// and mode write sends data_byte least significant bit first followed by the acknowledge
// window; dio_in is the data line level the device shows in that window. An unused mode
// is taken and produces nothing. Every pin phase comes out as one request on the result
// port, oldest first, while empty is low; it is taken at an edge with pop high.
// A taken command passes the command queue, the sequencer state register and the result queue
// before its first phase shows on the result port. Each pin phase is held for the time set in
// the phase hold register; a start or stop has four phases and a byte write thirty. Without an
// acknowledge the release phase also waits until the poll counter, loaded from the acknowledge
// timeout register, has run out. Between commands the sequencer passes through its idle state.
// The hold and poll counters of the sequencer set this timing; two commands can wait before it.
// When the receiver stalls, the two-entry result queue fills and the sequencer stops at
// the next phase boundary; the command queue keeps taking requests until it holds two.
// Reset clears both queues, puts the clock and data pins low with data driven, and loads the
// registers with a hold of 100 and an acknowledge timeout of 300. The user must write them
// via cfg_we, cfg_index and cfg_wdata only while the block is idle; the block does not check.
`default_nettype none
module two_wire_serial_write_master_unit (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            push,
	output logic                           full,
	input  wire twsw_pkg::cmd_t            cmd,
	output logic                           empty,
	input  wire                            pop,
	output twsw_pkg::rsp_t                 rsp,
	input  wire                            cfg_we,
	input  wire                            cfg_index,
	input  wire [twsw_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	logic [twsw_pkg::HOLD_W-1:0]    phase_hold_q;
	logic [twsw_pkg::TIMEOUT_W-1:0] ack_timeout_q;
	logic                           entry_valid;
	twsw_pkg::cmd_entry_t           entry;
	logic                           entry_take;
	logic                           seq_push;
	twsw_pkg::rsp_t                 seq_rsp;
	logic                           rsp_full;

	// Configuration registers; the timeout keeps the low ten bits of the write data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_hold_q  <= twsw_pkg::PHASE_HOLD_RESET;
			ack_timeout_q <= twsw_pkg::ACK_TIMEOUT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				twsw_pkg::CFG_PHASE_HOLD:  phase_hold_q <= cfg_wdata;
				twsw_pkg::CFG_ACK_TIMEOUT: ack_timeout_q <= cfg_wdata[twsw_pkg::TIMEOUT_W-1:0];
				default:                   phase_hold_q <= phase_hold_q;
			endcase
		end
	end

	// Front end: takes requests and drops unused modes before they are queued.
	twsw_cmd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.cmd         (cmd),
		.entry_valid (entry_valid),
		.entry       (entry),
		.entry_take  (entry_take)
	);

	// Back end: one command at a time, one pin phase per hold period unless polling or stalled.
	twsw_phase_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.phase_hold  (phase_hold_q),
		.ack_timeout (ack_timeout_q),
		.entry_valid (entry_valid),
		.entry       (entry),
		.entry_take  (entry_take),
		.rsp_push    (seq_push),
		.rsp         (seq_rsp),
		.rsp_full    (rsp_full)
	);

	// Result queue decouples the sequencer from a stalling receiver.
	twsw_rsp_fifo u_rsp_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (seq_push),
		.wr_data (seq_rsp),
		.full    (rsp_full),
		.empty   (empty),
		.pop     (pop),
		.rd_data (rsp)
	);

endmodule
`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the two-wire serial write master unit.
module tb;
	import twsw_pkg::*;

	localparam int HALF_PERIOD = 10;
	localparam int RESET_CYCLES = 7;
	// The slowest legal run is dominated by one start at the longest hold plus the settle time
	// after it. This limit is several times that run.
	localparam int CYCLE_LIMIT = 2_000_000;
	// The mode field has one code that the package does not name; the block ignores it.
	localparam logic [1:0] MODE_UNUSED = 2'd3;
	// Length of the one long receiver hold-off, in cycles.
	localparam int FLOOD_CYCLES = 600;

	// The scoreboard keeps its own copy of the pin registers and the timing registers, expands
	// every accepted command into the pin phases it must produce, and checks each popped phase
	// against the oldest one still due.
	class pin_phase_board;
		rsp_t phases_due[$];
		logic pin_clk;
		logic pin_dio;
		logic pin_drive;
		logic [HOLD_W-1:0] hold_cycles;
		logic [TIMEOUT_W-1:0] poll_limit;
		int errors;
		int checked;
		int starts;
		int stops;
		int writes;
		int unused;

		function new();
			pin_clk = 1'b0;
			pin_dio = 1'b0;
			pin_drive = 1'b1;
			hold_cycles = PHASE_HOLD_RESET;
			poll_limit = ACK_TIMEOUT_RESET;
			errors = 0;
			checked = 0;
			starts = 0;
			stops = 0;
			writes = 0;
			unused = 0;
		endfunction

		// The timing registers never change a phase, but the settle time depends on them.
		function void set_register(logic idx, logic [CFG_DATA_W-1:0] value);
			if (idx == CFG_PHASE_HOLD) begin
				hold_cycles = value[HOLD_W-1:0];
			end else begin
				poll_limit = value[TIMEOUT_W-1:0];
			end
		endfunction

		function void push_phase(logic ack, logic last);
			rsp_t r;
			r.clk_level = pin_clk;
			r.dio_level = pin_dio;
			r.dio_drive = pin_drive;
			r.ack_seen = ack;
			r.last_phase = last;
			phases_due.push_back(r);
		endfunction

		function void note_command(cmd_t c);
			int b;
			logic ack;
			case (c.mode)
				MODE_START: begin
					starts++;
					pin_dio = 1'b0; push_phase(1'b0, 1'b0);
					pin_clk = 1'b0; push_phase(1'b0, 1'b0);
					pin_dio = 1'b1; push_phase(1'b0, 1'b0);
					pin_clk = 1'b1; push_phase(1'b0, 1'b1);
				end
				MODE_STOP: begin
					stops++;
					pin_clk = 1'b0; push_phase(1'b0, 1'b0);
					pin_dio = 1'b0; push_phase(1'b0, 1'b0);
					pin_clk = 1'b1; push_phase(1'b0, 1'b0);
					pin_dio = 1'b1; push_phase(1'b0, 1'b1);
				end
				MODE_WRITE: begin
					writes++;
					for (b = 0; b < 8; b++) begin
						pin_clk = 1'b0; push_phase(1'b0, 1'b0);
						pin_dio = c.data_byte[b]; push_phase(1'b0, 1'b0);
						pin_clk = 1'b1; push_phase(1'b0, 1'b0);
					end
					pin_clk = 1'b0; push_phase(1'b0, 1'b0);
					pin_dio = 1'b1; push_phase(1'b0, 1'b0);
					pin_clk = 1'b1; push_phase(1'b0, 1'b0);
					// The data line is released for the acknowledge; a high line means none came,
					// and the sequence carries on regardless of the poll limit.
					pin_drive = 1'b0; push_phase(1'b0, 1'b0);
					ack = ~c.dio_in;
					pin_drive = 1'b1; push_phase(1'b0, 1'b0);
					pin_dio = 1'b0; push_phase(ack, 1'b1);
				end
				default: begin
					// The unused code is taken but produces nothing and leaves the pins alone.
					unused++;
				end
			endcase
		endfunction

		function void report(string field, logic want, logic got);
			errors++;
			$display("%0t: %s mismatch: expected %b, actual %b", $time, field, want, got);
		endfunction

		function void check_phase(rsp_t got);
			rsp_t want;
			checked++;
			if (phases_due.size() == 0) begin
				errors++;
				$display("%0t: pin phase with nothing expected: expected none, actual %b",
					$time, got);
				return;
			end
			want = phases_due.pop_front();
			if (got.clk_level !== want.clk_level) report("clk_level", want.clk_level, got.clk_level);
			if (got.dio_level !== want.dio_level) report("dio_level", want.dio_level, got.dio_level);
			if (got.dio_drive !== want.dio_drive) report("dio_drive", want.dio_drive, got.dio_drive);
			if (got.ack_seen !== want.ack_seen) report("ack_seen", want.ack_seen, got.ack_seen);
			if (got.last_phase !== want.last_phase) begin
				report("last_phase", want.last_phase, got.last_phase);
			end
		endfunction
	endclass

	// Every input of the block holds a known value from time zero.
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	cmd_t cmd = '0;
	logic pop = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic full;
	logic empty;
	rsp_t rsp;

	pin_phase_board board;
	cmd_t plan[$];
	int unsigned cycle_count = 0;
	int full_stalls = 0;
	int random_taken = 0;
	bit flood_armed = 1'b0;
	bit flood_done = 1'b0;

	two_wire_serial_write_master_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.cmd(cmd),
		.empty(empty),
		.pop(pop),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #HALF_PERIOD clk = ~clk;

	// Watchdog: a hung handshake or a missing phase ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("two_wire_serial_write_master_unit regression: fail");
			$finish;
		end
	end

	function automatic cmd_t make_cmd(logic [1:0] mode, logic [7:0] data, logic dio);
		cmd_t c;
		c.mode = mode;
		c.data_byte = data;
		c.dio_in = dio;
		return c;
	endfunction

	// Sends the planned commands in bursts of random length. Within a burst push stays high
	// and only the command changes; between bursts push drops for a random gap. A request
	// counts as taken at the first edge where full was low.
	task automatic offer_plan();
		int burst;
		int gap;
		cmd_t c;
		burst = $urandom_range(1, 8);
		while (plan.size() > 0) begin
			c = plan.pop_front();
			push <= 1'b1;
			cmd <= c;
			do begin
				@(posedge clk);
				if (full) full_stalls++;
			end while (full);
			board.note_command(c);
			burst--;
			if (plan.size() == 0) begin
				push <= 1'b0;
			end else if (burst == 0) begin
				burst = $urandom_range(1, 8);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				if (gap > 0) begin
					push <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
	endtask

	// Random traffic is mostly whole transactions: a start, one to four byte writes with a
	// mostly acknowledged line, and a stop. The rest is single commands of any code, which
	// gives broken sequences such as writes outside a transaction or doubled starts.
	task automatic plan_random(int count);
		int n;
		int k;
		int w;
		logic [1:0] mode;
		n = 0;
		while (n < count) begin
			if ($urandom_range(0, 9) < 8) begin
				plan.push_back(make_cmd(MODE_START, 8'($urandom), 1'($urandom)));
				w = $urandom_range(1, 4);
				for (k = 0; k < w; k++) begin
					plan.push_back(make_cmd(MODE_WRITE, 8'($urandom), $urandom_range(0, 3) == 0));
				end
				plan.push_back(make_cmd(MODE_STOP, 8'($urandom), 1'($urandom)));
				n += w + 2;
			end else begin
				mode = 2'($urandom_range(0, 3));
				plan.push_back(make_cmd(mode, 8'($urandom), 1'($urandom)));
				if (mode != MODE_UNUSED) n++;
			end
		end
	endtask

	// Waits for every due phase, then for the rest of the last held phase and any acknowledge
	// polling, so that the sequencer is idle before the registers change.
	task automatic settle();
		int extra;
		while (board.phases_due.size() != 0) @(posedge clk);
		extra = int'(board.hold_cycles) + int'(board.poll_limit) + 16;
		repeat (extra) @(posedge clk);
	endtask

	// Both registers are written on back-to-back edges with the write enable held high.
	task automatic program_timing(logic [HOLD_W-1:0] hold, logic [TIMEOUT_W-1:0] polls);
		cfg_we <= 1'b1;
		cfg_index <= CFG_PHASE_HOLD;
		cfg_wdata <= CFG_DATA_W'(hold);
		@(posedge clk);
		cfg_index <= CFG_ACK_TIMEOUT;
		cfg_wdata <= CFG_DATA_W'(polls);
		@(posedge clk);
		cfg_we <= 1'b0;
		board.set_register(CFG_PHASE_HOLD, CFG_DATA_W'(hold));
		board.set_register(CFG_ACK_TIMEOUT, CFG_DATA_W'(polls));
	endtask

	// Result side. The pop pattern is redrawn after each random span among always ready, mostly
	// ready, mostly stalled and nearly stopped. Once during the first random phase it holds off
	// entirely for a long stretch so that both queues fill and full pushes back on the sender.
	initial begin : result_side
		int span;
		int stall_mode;
		int flood_left;
		span = 0;
		stall_mode = 0;
		flood_left = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				board.check_phase(rsp);
				if (flood_armed) random_taken++;
			end
			if (span == 0) begin
				stall_mode = $urandom_range(0, 3);
				span = $urandom_range(10, 120);
			end else begin
				span--;
			end
			if (flood_armed && !flood_done && random_taken >= 30) begin
				flood_left = FLOOD_CYCLES;
				flood_done = 1'b1;
			end
			if (flood_left > 0) begin
				flood_left--;
				pop <= 1'b0;
			end else begin
				case (stall_mode)
					0: pop <= 1'b1;
					1: pop <= ($urandom_range(0, 3) != 0);
					2: pop <= ($urandom_range(0, 3) == 0);
					default: pop <= ($urandom_range(0, 15) == 0);
				endcase
			end
		end
	end

	initial begin : stimulus
		board = new();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset timing: a full transaction with an acknowledged all-zero byte and an unacknowledged
		// all-ones byte, a lone write and stop, the unused code, and ignored fields on start and stop.
		plan.push_back(make_cmd(MODE_START, 8'hFF, 1'b1));
		plan.push_back(make_cmd(MODE_WRITE, 8'h00, 1'b0));
		plan.push_back(make_cmd(MODE_WRITE, 8'hFF, 1'b1));
		plan.push_back(make_cmd(MODE_STOP, 8'h00, 1'b0));
		plan.push_back(make_cmd(MODE_UNUSED, 8'hFF, 1'b1));
		plan.push_back(make_cmd(MODE_WRITE, 8'hA5, 1'b0));
		plan.push_back(make_cmd(MODE_STOP, 8'hFF, 1'b1));
		plan.push_back(make_cmd(MODE_UNUSED, 8'h00, 1'b0));
		offer_plan();

		// Shortest hold and no acknowledge polls: a missing acknowledge must still finish the
		// byte. Writes outside a transaction and repeated starts and stops are also sent.
		settle();
		program_timing(16'd1, 10'd0);
		plan.push_back(make_cmd(MODE_WRITE, 8'h01, 1'b1));
		plan.push_back(make_cmd(MODE_WRITE, 8'h80, 1'b0));
		plan.push_back(make_cmd(MODE_START, 8'h00, 1'b0));
		plan.push_back(make_cmd(MODE_START, 8'h3C, 1'b1));
		plan.push_back(make_cmd(MODE_STOP, 8'hC3, 1'b0));
		plan.push_back(make_cmd(MODE_STOP, 8'h00, 1'b1));
		plan.push_back(make_cmd(MODE_WRITE, 8'h5A, 1'b1));
		plan.push_back(make_cmd(MODE_UNUSED, 8'h5A, 1'b0));
		offer_plan();

		// Longest acknowledge wait, with the device never answering.
		settle();
		program_timing(16'd3, 10'd1023);
		plan.push_back(make_cmd(MODE_START, 8'h00, 1'b0));
		plan.push_back(make_cmd(MODE_WRITE, 8'hFF, 1'b1));
		plan.push_back(make_cmd(MODE_WRITE, 8'h00, 1'b1));
		plan.push_back(make_cmd(MODE_STOP, 8'h00, 1'b0));
		offer_plan();

		// Longest hold: a single start keeps the run short.
		settle();
		program_timing(16'hFFFF, 10'd7);
		plan.push_back(make_cmd(MODE_START, 8'hAA, 1'b0));
		offer_plan();

		// Random traffic at short holds, in two halves with fresh timing in each. The long
		// receiver hold-off happens in the first half.
		settle();
		program_timing(HOLD_W'($urandom_range(1, 4)), TIMEOUT_W'($urandom_range(0, 40)));
		flood_armed = 1'b1;
		plan_random(100);
		offer_plan();

		settle();
		program_timing(HOLD_W'($urandom_range(1, 4)), TIMEOUT_W'($urandom_range(0, 40)));
		plan_random(100);
		offer_plan();

		settle();
		$display("Sent %0d starts, %0d stops, %0d byte writes and %0d unused codes at six timings.",
			board.starts, board.stops, board.writes, board.unused);
		$display("Checked %0d pin phases; full held the sender off on %0d cycles.",
			board.checked, full_stalls);
		if (board.errors == 0) begin
			$display("two_wire_serial_write_master_unit regression: pass");
		end else begin
			$display("two_wire_serial_write_master_unit regression: fail");
		end
		$finish;
	end

endmodule
